FILE: rtl/core/resp_stream_parser_top_assert.svh
// ---------------------------------------------------------------------------
// RESP stream parser assertion macros
// Shared concurrent assertion forms for the parser checker.
// ---------------------------------------------------------------------------
`ifndef RESP_STREAM_PARSER_TOP_ASSERT_SVH
`define RESP_STREAM_PARSER_TOP_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define RSP_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define RSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/rsp_pkg.sv
// ---------------------------------------------------------------------------
// RESP stream parser package
// Transaction types, phase and event codes and sizing constants.
// ---------------------------------------------------------------------------
package rsp_pkg;

    localparam int MAX_DEPTH = 8;
    localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int LVL_W = $clog2(MAX_DEPTH + 1);

    localparam logic [2:0] PH_TYPE      = 3'd0;
    localparam logic [2:0] PH_LINE      = 3'd1;
    localparam logic [2:0] PH_NUM       = 3'd2;
    localparam logic [2:0] PH_SKIP      = 3'd3;
    localparam logic [2:0] PH_SKIP_BULK = 3'd4;
    localparam logic [2:0] PH_BULK      = 3'd5;
    localparam logic [2:0] PH_TRAIL     = 3'd6;

    localparam logic [2:0] K_PAYLOAD = 3'd0;
    localparam logic [2:0] K_END     = 3'd1;
    localparam logic [2:0] K_INT     = 3'd2;
    localparam logic [2:0] K_BULK    = 3'd3;
    localparam logic [2:0] K_ARRAY   = 3'd4;
    localparam logic [2:0] K_NULL    = 3'd5;
    localparam logic [2:0] K_ERROR   = 3'd6;

    localparam logic [2:0] T_PLUS   = 3'd0;
    localparam logic [2:0] T_MINUS  = 3'd1;
    localparam logic [2:0] T_COLON  = 3'd2;
    localparam logic [2:0] T_DOLLAR = 3'd3;
    localparam logic [2:0] T_STAR   = 3'd4;

    localparam logic [1:0] E_NONE  = 2'd0;
    localparam logic [1:0] E_TYPE  = 2'd1;
    localparam logic [1:0] E_NUM   = 2'd2;
    localparam logic [1:0] E_DEPTH = 2'd3;

    localparam logic [1:0] D_NONE = 2'd0;
    localparam logic [1:0] D_SIGN = 2'd1;
    localparam logic [1:0] D_DIG  = 2'd2;
    localparam logic [1:0] D_TAIL = 2'd3;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         kind;
        logic [2:0]         type_code;
        logic [7:0]         payload_byte;
        logic signed [31:0] number_value;
        logic [3:0]         nest_depth;
        logic               message_done;
        logic [1:0]         error_code;
    } t_out_item;

endpackage

FILE: rtl/core/resp_stream_parser_top.sv
// ---------------------------------------------------------------------------
// RESP stream parser
// Byte-serial RESP2 parser that turns each stream byte into at most one event.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_in_data  (t_in_item)
// output    out        o_out_valid / i_out_ready  o_out_data (t_out_item)
//
// One byte is accepted per cycle; its event appears in the output register
// on the next cycle. The stack of open array counts is updated in the same
// cycle as the byte that closes or opens arrays. Input stalls only while a
// finished event waits in the output register. Reset is synchronous.
// ---------------------------------------------------------------------------
module resp_stream_parser_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rsp_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rsp_pkg::t_out_item o_out_data
);
    import rsp_pkg::*;

    logic [2:0]       r_phase, n_phase, e_phase;
    logic [2:0]       r_etype, n_etype, e_etype;
    logic             r_neg, n_neg, e_neg;
    logic [31:0]      r_acc, n_acc, e_acc;
    logic [1:0]       r_dig, n_dig, e_dig;
    logic [31:0]      r_bulk, n_bulk, e_bulk;
    logic [LVL_W-1:0] r_lvl, n_lvl, e_lvl;
    logic             r_err, n_err, e_err;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [31:0]      r_cnt [MAX_DEPTH];
    logic [MAX_DEPTH-1:0] r_one;

    logic             accept;
    logic             ev_valid;
    t_out_item        ev;
    logic             do_cmp;
    logic             do_push;
    logic [LVL_W-1:0] cmp_lvl;
    logic             cmp_done;
    logic             stop;
    logic [IDX_W-1:0] upd_idx;
    logic [31:0]      upd_val;
    logic             upd_one;
    logic [7:0]       c;
    logic             is_digit;
    logic [35:0]      m;
    logic [35:0]      lim;
    logic [31:0]      v;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign c          = i_in_data.data_byte;
    assign is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);

    always_comb begin
        e_phase = i_in_data.restart ? PH_TYPE : r_phase;
        e_etype = i_in_data.restart ? T_PLUS : r_etype;
        e_neg   = i_in_data.restart ? 1'b0 : r_neg;
        e_acc   = i_in_data.restart ? 32'd0 : r_acc;
        e_dig   = i_in_data.restart ? D_NONE : r_dig;
        e_bulk  = i_in_data.restart ? 32'd0 : r_bulk;
        e_lvl   = i_in_data.restart ? '0 : r_lvl;
        e_err   = i_in_data.restart ? 1'b0 : r_err;
    end

    always_comb begin
        cmp_lvl = e_lvl;
        stop    = 1'b0;
        for (int i = 0; i < MAX_DEPTH; i++) begin
            if (!stop && cmp_lvl != '0 && r_one[IDX_W'(cmp_lvl - 1'b1)]) begin
                cmp_lvl = cmp_lvl - 1'b1;
            end else begin
                stop = 1'b1;
            end
        end
        cmp_done = (cmp_lvl == '0);
    end

    assign m   = ({4'd0, e_acc} << 3) + ({4'd0, e_acc} << 1) + {28'd0, c - CH_ZERO};
    assign lim = e_neg ? 36'h080000000 : 36'h07FFFFFFF;
    assign v   = e_neg ? (32'd0 - e_acc) : e_acc;

    always_comb begin
        n_phase  = e_phase;
        n_etype  = e_etype;
        n_neg    = e_neg;
        n_acc    = e_acc;
        n_dig    = e_dig;
        n_bulk   = e_bulk;
        n_lvl    = e_lvl;
        n_err    = e_err;
        ev_valid = 1'b0;
        do_cmp   = 1'b0;
        do_push  = 1'b0;
        ev       = '0;
        ev.nest_depth = 4'(e_lvl);
        if (!e_err) begin
            unique case (e_phase)
                PH_TYPE: begin
                    n_neg   = 1'b0;
                    n_acc   = 32'd0;
                    n_dig   = D_NONE;
                    n_phase = PH_NUM;
                    unique case (c)
                        CH_PLUS:   begin n_etype = T_PLUS;   n_phase = PH_LINE; end
                        CH_MINUS:  begin n_etype = T_MINUS;  n_phase = PH_LINE; end
                        CH_COLON:  n_etype = T_COLON;
                        CH_DOLLAR: n_etype = T_DOLLAR;
                        CH_STAR:   n_etype = T_STAR;
                        default: begin
                            n_etype = T_PLUS;
                            n_phase = PH_TYPE;
                            n_err = 1'b1;
                            ev_valid = 1'b1;
                            ev.kind = K_ERROR;
                            ev.error_code = E_TYPE;
                        end
                    endcase
                end
                PH_LINE: begin
                    ev_valid = 1'b1;
                    if (c == CH_CR) begin
                        n_phase = PH_SKIP;
                        ev.kind = K_END;
                        do_cmp  = 1'b1;
                    end else begin
                        ev.kind = K_PAYLOAD;
                        ev.payload_byte = c;
                    end
                end
                PH_NUM: begin
                    if (c == CH_CR) begin
                        ev_valid = 1'b1;
                        if (e_dig != D_DIG && e_dig != D_TAIL) begin
                            n_err = 1'b1;
                            ev.kind = K_ERROR;
                            ev.error_code = E_NUM;
                        end else begin
                            n_phase = PH_SKIP;
                            ev.number_value = v;
                            if (e_etype == T_COLON) begin
                                ev.kind = K_INT;
                                do_cmp  = 1'b1;
                            end else if (e_neg && e_acc != 32'd0) begin
                                ev.kind = K_NULL;
                                do_cmp  = 1'b1;
                            end else if (e_etype == T_DOLLAR) begin
                                ev.kind = K_BULK;
                                n_bulk  = v;
                                n_phase = PH_SKIP_BULK;
                            end else if (v == 32'd0) begin
                                ev.kind = K_ARRAY;
                                do_cmp  = 1'b1;
                            end else if (e_lvl >= LVL_W'(MAX_DEPTH)) begin
                                n_err = 1'b1;
                                ev.kind = K_ERROR;
                                ev.number_value = '0;
                                ev.error_code = E_DEPTH;
                            end else begin
                                ev.kind = K_ARRAY;
                                do_push = 1'b1;
                                n_lvl   = e_lvl + 1'b1;
                            end
                        end
                    end else if (e_dig == D_NONE && c == CH_SPACE) begin
                        n_dig = D_NONE;
                    end else if (e_dig == D_NONE && (c == CH_PLUS || c == CH_MINUS)) begin
                        n_neg = (c == CH_MINUS);
                        n_dig = D_SIGN;
                    end else if (e_dig == D_TAIL) begin
                        n_dig = D_TAIL;
                    end else if (!is_digit) begin
                        if (e_dig == D_DIG) begin
                            n_dig = D_TAIL;
                        end else begin
                            n_err = 1'b1;
                            ev_valid = 1'b1;
                            ev.kind = K_ERROR;
                            ev.error_code = E_NUM;
                        end
                    end else if (m > lim) begin
                        n_err = 1'b1;
                        ev_valid = 1'b1;
                        ev.kind = K_ERROR;
                        ev.error_code = E_NUM;
                    end else begin
                        n_acc = m[31:0];
                        n_dig = D_DIG;
                    end
                end
                PH_SKIP_BULK: begin
                    n_phase = (e_bulk == 32'd0) ? PH_TRAIL : PH_BULK;
                end
                PH_BULK: begin
                    n_bulk = e_bulk - 32'd1;
                    if (e_bulk == 32'd1) begin
                        n_phase = PH_TRAIL;
                    end
                    ev_valid = 1'b1;
                    ev.kind = K_PAYLOAD;
                    ev.payload_byte = c;
                end
                PH_TRAIL: begin
                    n_phase  = PH_SKIP;
                    ev_valid = 1'b1;
                    ev.kind  = K_END;
                    do_cmp   = 1'b1;
                end
                default: begin
                    n_phase = PH_TYPE;
                end
            endcase
        end
        if (do_cmp) begin
            n_lvl = cmp_lvl;
            ev.message_done = cmp_done;
        end
        ev.type_code = n_etype;
    end

    always_comb begin
        if (do_push) begin
            upd_idx = IDX_W'(e_lvl);
            upd_val = v;
            upd_one = (v == 32'd1);
        end else begin
            upd_idx = IDX_W'(cmp_lvl - 1'b1);
            upd_val = r_cnt[IDX_W'(cmp_lvl - 1'b1)] - 32'd1;
            upd_one = (r_cnt[IDX_W'(cmp_lvl - 1'b1)] == 32'd2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (do_push || (do_cmp && !cmp_done))) begin
            r_cnt[upd_idx] <= upd_val;
            r_one[upd_idx] <= upd_one;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TYPE;
            r_etype     <= T_PLUS;
            r_neg       <= 1'b0;
            r_acc       <= 32'd0;
            r_dig       <= D_NONE;
            r_bulk      <= 32'd0;
            r_lvl       <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_etype <= n_etype;
                r_neg   <= n_neg;
                r_acc   <= n_acc;
                r_dig   <= n_dig;
                r_bulk  <= n_bulk;
                r_lvl   <= n_lvl;
                r_err   <= n_err;
            end
            if (o_in_ready) begin
                r_out_valid <= accept && ev_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_out <= ev;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/core/rsp_checker.sv
// ---------------------------------------------------------------------------
// RESP stream parser checker
// Port-level checks on the parser's output transactions.
// ---------------------------------------------------------------------------
`include "resp_stream_parser_top_assert.svh"

module rsp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input rsp_pkg::t_out_item o_out_data
);
    import rsp_pkg::*;

    logic      vld;
    t_out_item dat;
    logic      stall;
    logic      is_err;
    logic      no_code;
    logic      err_ok;
    logic      depth_ok;

    assign vld      = o_out_valid;
    assign dat      = o_out_data;
    assign stall    = o_out_valid && !i_out_ready;
    assign is_err   = (o_out_data.kind == K_ERROR);
    assign no_code  = (o_out_data.error_code == E_NONE);
    assign err_ok   = !no_code && !o_out_data.message_done;
    assign depth_ok = (o_out_data.nest_depth <= 4'(MAX_DEPTH));

    `RSP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, stall, vld && $stable(dat), "Output not held.")
    `RSP_ASSERT(a_err_only, i_clk, i_rst_n, vld && !is_err, no_code, "Stray error code.")
    `RSP_ASSERT(a_err_code, i_clk, i_rst_n, vld && is_err, err_ok, "Error without code.")
    `RSP_ASSERT(a_depth, i_clk, i_rst_n, vld, depth_ok, "Depth beyond stack.")

endmodule

bind resp_stream_parser_top rsp_checker u_rsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

FILE: bench/tb_resp_stream_parser_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RESP stream parser testbench
// Drives a directed table and then random RESP elements through the parser.
// Each event is checked against a bit-accurate predictor or a literal table
// row, and both channels are stalled in random bursts.
// ---------------------------------------------------------------------------
module tb_resp_stream_parser_top;
    import rsp_pkg::*;

    localparam int RAND_ITEMS = 1550;
    localparam int QUIET_AT   = 1400;
    localparam int WDOG_LIMIT = 4000;

    typedef struct {
        logic [7:0] b;
        bit         rs;
        bit         lit;
        t_out_item  ev;
    } t_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    resp_stream_parser_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    // Parser state as predicted.
    logic [2:0]  ps_phase = PH_TYPE;
    logic [2:0]  ps_type = T_PLUS;
    bit          ps_neg = 0;
    logic [31:0] ps_acc = '0;
    logic [1:0]  ps_digits = D_NONE;
    logic [31:0] ps_bulk_left = '0;
    logic [31:0] ps_counts [MAX_DEPTH];
    int          ps_level = 0;
    bit          ps_err = 0;

    t_out_item   expected_events[$];
    bit          lit_flags[$];
    t_out_item   lit_events[$];
    t_row        dir_rows[$];
    t_in_item    gen_bytes[$];

    int  fail_count = 0;
    int  sent_count = 0;
    int  event_count = 0;
    int  error_events = 0;
    int  deepest = 0;
    bit  quiet = 0;
    int  idle_cycles = 0;
    int  out_burst = 0;

    function automatic void clear_parser();
        ps_phase = PH_TYPE;
        ps_type = T_PLUS;
        ps_neg = 0;
        ps_acc = '0;
        ps_digits = D_NONE;
        ps_bulk_left = '0;
        for (int i = 0; i < MAX_DEPTH; i++) ps_counts[i] = '0;
        ps_level = 0;
        ps_err = 0;
    endfunction

    function automatic t_out_item make_event(logic [2:0] k, logic [7:0] pay,
                                             logic [31:0] num, int depth, bit done,
                                             logic [1:0] code);
        t_out_item o;
        o.kind = k;
        o.type_code = ps_type;
        o.payload_byte = pay;
        o.number_value = num;
        o.nest_depth = depth[3:0];
        o.message_done = done;
        o.error_code = code;
        return o;
    endfunction

    function automatic bit close_element();
        forever begin
            if (ps_level == 0 || ps_level > MAX_DEPTH) return 1;
            ps_counts[ps_level - 1] = ps_counts[ps_level - 1] - 1;
            if (ps_counts[ps_level - 1] != 0) return 0;
            ps_level--;
        end
    endfunction

    function automatic t_out_item raise_error(logic [1:0] code);
        ps_err = 1;
        return make_event(K_ERROR, 8'h00, 32'd0, ps_level, 0, code);
    endfunction

    function automatic t_out_item end_header();
        logic [31:0] v;
        int depth;
        bit done;
        v = ps_neg ? 32'd0 - ps_acc : ps_acc;
        depth = ps_level;
        ps_phase = PH_SKIP;
        if (ps_type == T_COLON) begin
            done = close_element();
            return make_event(K_INT, 8'h00, v, depth, done, E_NONE);
        end
        if (ps_neg && ps_acc != 0) begin
            done = close_element();
            return make_event(K_NULL, 8'h00, v, depth, done, E_NONE);
        end
        if (ps_type == T_DOLLAR) begin
            ps_bulk_left = v;
            ps_phase = PH_SKIP_BULK;
            return make_event(K_BULK, 8'h00, v, depth, 0, E_NONE);
        end
        if (v == 0) begin
            done = close_element();
            return make_event(K_ARRAY, 8'h00, 32'd0, depth, done, E_NONE);
        end
        if (ps_level >= MAX_DEPTH) return raise_error(E_DEPTH);
        ps_counts[ps_level] = v;
        ps_level++;
        return make_event(K_ARRAY, 8'h00, v, depth, 0, E_NONE);
    endfunction

    function automatic bit parse_byte(t_in_item it, output t_out_item o);
        logic [7:0] c;
        logic [63:0] m;
        logic [63:0] lim;
        int depth;
        bit done;
        c = it.data_byte;
        o = '0;
        if (it.restart) clear_parser();
        if (ps_err) return 0;
        case (ps_phase)
            PH_TYPE: begin
                if (c == CH_PLUS) ps_type = T_PLUS;
                else if (c == CH_MINUS) ps_type = T_MINUS;
                else if (c == CH_COLON) ps_type = T_COLON;
                else if (c == CH_DOLLAR) ps_type = T_DOLLAR;
                else if (c == CH_STAR) ps_type = T_STAR;
                else begin
                    ps_type = T_PLUS;
                    o = raise_error(E_TYPE);
                    return 1;
                end
                ps_neg = 0;
                ps_acc = '0;
                ps_digits = D_NONE;
                ps_phase = (ps_type <= T_MINUS) ? PH_LINE : PH_NUM;
                return 0;
            end
            PH_LINE: begin
                if (c == CH_CR) begin
                    depth = ps_level;
                    ps_phase = PH_SKIP;
                    done = close_element();
                    o = make_event(K_END, 8'h00, 32'd0, depth, done, E_NONE);
                    return 1;
                end
                o = make_event(K_PAYLOAD, c, 32'd0, ps_level, 0, E_NONE);
                return 1;
            end
            PH_NUM: begin
                if (c == CH_CR) begin
                    o = (ps_digits < D_DIG) ? raise_error(E_NUM) : end_header();
                    return 1;
                end
                if (ps_digits == D_NONE && c == CH_SPACE) return 0;
                if (ps_digits == D_NONE && (c == CH_PLUS || c == CH_MINUS)) begin
                    ps_neg = (c == CH_MINUS);
                    ps_digits = D_SIGN;
                    return 0;
                end
                if (ps_digits == D_TAIL) return 0;
                if (c < CH_ZERO || c > CH_NINE) begin
                    if (ps_digits == D_DIG) begin
                        ps_digits = D_TAIL;
                        return 0;
                    end
                    o = raise_error(E_NUM);
                    return 1;
                end
                m = {32'd0, ps_acc} * 64'd10 + {56'd0, c - CH_ZERO};
                lim = ps_neg ? 64'd2147483648 : 64'd2147483647;
                if (m > lim) begin
                    o = raise_error(E_NUM);
                    return 1;
                end
                ps_acc = m[31:0];
                ps_digits = D_DIG;
                return 0;
            end
            PH_SKIP_BULK: begin
                ps_phase = (ps_bulk_left == 0) ? PH_TRAIL : PH_BULK;
                return 0;
            end
            PH_BULK: begin
                ps_bulk_left = ps_bulk_left - 1;
                if (ps_bulk_left == 0) ps_phase = PH_TRAIL;
                o = make_event(K_PAYLOAD, c, 32'd0, ps_level, 0, E_NONE);
                return 1;
            end
            PH_TRAIL: begin
                depth = ps_level;
                ps_phase = PH_SKIP;
                done = close_element();
                o = make_event(K_END, 8'h00, 32'd0, depth, done, E_NONE);
                return 1;
            end
            default: begin
                ps_phase = PH_TYPE;
                return 0;
            end
        endcase
    endfunction

    // Stream generation.
    function automatic void put_byte(logic [7:0] b);
        t_in_item it;
        it.data_byte = b;
        it.restart = ($urandom_range(0, 299) == 0);
        gen_bytes.push_back(it);
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endfunction

    function automatic void put_line_end();
        put_byte(CH_CR);
        put_byte(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h0A);
    endfunction

    function automatic string number_text(int v);
        string s;
        int pick;
        pick = $urandom_range(0, 19);
        s = $sformatf("%0d", v);
        if (pick == 0) s = "2147483648";
        else if (pick == 1) s = "-2147483649";
        else if (pick == 2) s = "99999999999";
        else if (pick == 3) s = ($urandom_range(0, 1) != 0) ? "-" : "";
        else if (pick == 4) s = "x1";
        else if (pick == 5 && v >= 0) s = {"+", s};
        else if (pick == 6) s = {"  ", s};
        else if (pick == 7) s = {s, "z9 "};
        else if (pick == 8) s = {" ", s, " 7"};
        return s;
    endfunction

    function automatic void gen_element(int depth, bit deep);
        int pick;
        int n;
        int v;
        pick = deep && depth < 10 ? 4 : $urandom_range(0, (depth < 3) ? 5 : 3);
        if (depth > deepest) deepest = depth;
        case (pick)
            0, 1: begin
                put_byte(pick == 0 ? CH_PLUS : CH_MINUS);
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++) begin
                    v = $urandom_range(0, 255);
                    put_byte(v == CH_CR ? 8'h41 : 8'(v));
                end
                put_line_end();
            end
            2: begin
                put_byte(CH_COLON);
                case ($urandom_range(0, 4))
                    0: v = 32'h7FFFFFFF;
                    1: v = 32'h80000000;
                    2: v = $urandom_range(0, 99);
                    default: v = $urandom;
                endcase
                put_text(number_text(v));
                put_line_end();
            end
            3: begin
                put_byte(CH_DOLLAR);
                v = ($urandom_range(0, 7) == 0) ? -$urandom_range(1, 3) : $urandom_range(0, 6);
                put_text(number_text(v));
                put_line_end();
                for (int i = 0; i < v; i++) put_byte(8'($urandom));
                put_byte(CH_CR);
                put_byte(8'h0A);
            end
            default: begin
                put_byte(CH_STAR);
                if (deep) v = 1;
                else if ($urandom_range(0, 7) == 0) v = -$urandom_range(1, 2);
                else v = $urandom_range(0, 3);
                put_text($sformatf("%0d", v));
                put_line_end();
                for (int i = 0; i < v; i++) gen_element(depth + 1, deep);
            end
        endcase
    endfunction

    task automatic drive_item(t_in_item it, bit lit, t_out_item ev);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        lit_flags.push_back(lit);
        lit_events.push_back(ev);
        forever begin
            @(negedge i_clk);
            if (o_in_ready) break;
        end
        @(posedge i_clk);
        sent_count++;
    endtask

    task automatic report(string field, longint e, longint a);
        $display("%0t: mismatch in %s, expected %0d, actual %0d", $time, field, e, a);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_item o;
        t_out_item got;
        t_out_item e;
        bit has_event;
        bit lit;
        if (i_rst_n && ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            has_event = parse_byte(i_in_data, o);
            lit = lit_flags.pop_front();
            e = lit_events.pop_front();
            if (has_event) expected_events.push_back(lit ? e : o);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = o_out_data;
            event_count++;
            if (got.kind == K_ERROR) error_events++;
            if (expected_events.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual kind %0d",
                         $time, got.kind);
                fail_count++;
            end else begin
                e = expected_events.pop_front();
                if (got.kind != e.kind) report("kind", e.kind, got.kind);
                if (got.type_code != e.type_code) report("type_code", e.type_code, got.type_code);
                if (got.payload_byte != e.payload_byte)
                    report("payload_byte", e.payload_byte, got.payload_byte);
                if (got.number_value != e.number_value)
                    report("number_value", e.number_value, got.number_value);
                if (got.nest_depth != e.nest_depth)
                    report("nest_depth", e.nest_depth, got.nest_depth);
                if (got.message_done != e.message_done)
                    report("message_done", e.message_done, got.message_done);
                if (got.error_code != e.error_code)
                    report("error_code", e.error_code, got.error_code);
            end
        end
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (out_burst > 0) begin
            out_burst <= out_burst - 1;
            i_out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            out_burst <= $urandom_range(0, 12);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    initial begin
        bit deep;
        clear_parser();
        dir_rows.push_back('{8'h00, 1, 1, '{K_ERROR, T_PLUS, 8'h00, 32'd0, 4'd0, 1'b0, E_TYPE}});
        dir_rows.push_back('{8'hFF, 1, 1, '{K_ERROR, T_PLUS, 8'h00, 32'd0, 4'd0, 1'b0, E_TYPE}});
        dir_rows.push_back('{CH_COLON, 1, 0, '0});
        dir_rows.push_back('{CH_CR, 0, 1, '{K_ERROR, T_COLON, 8'h00, 32'd0, 4'd0, 1'b0, E_NUM}});
        dir_rows.push_back('{CH_DOLLAR, 1, 0, '0});
        dir_rows.push_back('{CH_MINUS, 0, 0, '0});
        dir_rows.push_back('{8'h31, 0, 0, '0});
        dir_rows.push_back('{CH_CR, 0, 1,
                             '{K_NULL, T_DOLLAR, 8'h00, 32'hFFFFFFFF, 4'd0, 1'b1, E_NONE}});
        dir_rows.push_back('{8'h0A, 0, 0, '0});
        dir_rows.push_back('{CH_STAR, 0, 0, '0});
        dir_rows.push_back('{CH_ZERO, 0, 0, '0});
        dir_rows.push_back('{CH_CR, 0, 1, '{K_ARRAY, T_STAR, 8'h00, 32'd0, 4'd0, 1'b1, E_NONE}});
        dir_rows.push_back('{8'h0A, 0, 0, '0});
        dir_rows.push_back('{CH_MINUS, 0, 0, '0});
        dir_rows.push_back('{8'h80, 0, 0, '0});
        dir_rows.push_back('{8'h7F, 0, 0, '0});
        dir_rows.push_back('{CH_CR, 0, 0, '0});
        dir_rows.push_back('{8'h0A, 0, 0, '0});
        dir_rows.push_back('{CH_COLON, 0, 0, '0});
        dir_rows.push_back('{CH_SPACE, 0, 0, '0});
        dir_rows.push_back('{CH_NINE, 0, 0, '0});
        dir_rows.push_back('{CH_CR, 0, 0, '0});
        dir_rows.push_back('{8'h0A, 0, 0, '0});

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            drive_item('{dir_rows[i].b, dir_rows[i].rs}, dir_rows[i].lit, dir_rows[i].ev);

        while (sent_count < RAND_ITEMS + dir_rows.size()) begin
            gen_bytes.delete();
            if ($urandom_range(0, 19) == 0) begin
                repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
            end else begin
                deep = ($urandom_range(0, 24) == 0);
                gen_element(0, deep);
            end
            if ($urandom_range(0, 3) != 0 || ps_err) gen_bytes[0].restart = 1'b1;
            if (sent_count >= QUIET_AT) quiet = 1;
            foreach (gen_bytes[i]) drive_item(gen_bytes[i], 0, '0);
        end
        i_in_valid <= 1'b0;

        while (expected_events.size() != 0) @(negedge i_clk);
        repeat (5) @(posedge i_clk);

        $display("Sent %0d bytes and checked %0d events, %0d of them errors.",
                 sent_count, event_count, error_events);
        $display("Arrays were nested up to %0d levels with random stalls on both sides.",
                 deepest);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
